/* rtl/core/psg_three_channel_sample_renderer_unit_macros.svh */
// Assertion macros for the sample renderer
`ifndef PSG_THREE_CHANNEL_SAMPLE_RENDERER_UNIT_MACROS_SVH
`define PSG_THREE_CHANNEL_SAMPLE_RENDERER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and volume tables of the sample renderer.
// ----------------------------------------------------------------------------
`default_nettype none
package psg_pkg;
  localparam int NUM_REGS = 7;
  localparam int CFG_W = 36;
  localparam int IDX_W = 3;
  // tick count of one item is at most MAX_TICKS, and fits in 7 bits
  localparam int TICK_W = 7;
  localparam logic [IDX_W-1:0] REG_TONE = 3'd0;
  localparam logic [IDX_W-1:0] REG_NOISE = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIXER = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOL = 3'd3;
  localparam logic [IDX_W-1:0] REG_ENV = 3'd4;
  localparam logic [IDX_W-1:0] REG_CHIP = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEP = 3'd6;

  localparam logic signed [17:0] HP_COEF = 18'sd65460;
  localparam logic signed [15:0] LP_B0 = 16'sd7032;
  localparam logic signed [15:0] LP_B1 = 16'sd14063;
  localparam logic signed [15:0] LP_A1 = -16'sd4827;
  localparam logic signed [15:0] LP_A2 = 16'sd178;
  localparam logic signed [9:0] OUT_GAIN = 10'sd384;

  typedef struct packed {
    logic [35:0] tone_periods;
    logic [4:0]  noise_div;
    logic [8:0]  mixer_bits;
    logic [11:0] channel_volumes;
    logic [15:0] envelope_period;
    logic        chip_type;
    logic [21:0] sample_step;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic shape_load;
    logic phase_add;
    logic tick;
    logic div_start;
    logic div_step;
    logic filt_hp;
    logic filt_lp;
    logic filt_out;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
  } stat_t;

  function automatic logic [13:0] curve(input logic sel, input logic [3:0] v);
    logic [13:0] a [16];
    logic [13:0] b [16];
    a = '{14'h0000, 14'h006D, 14'h009E, 14'h00E6, 14'h014F, 14'h01F1, 14'h02C0,
          14'h0495, 14'h0566, 14'h08BE, 14'h0C77, 14'h0FE8, 14'h1503, 14'h1B1A,
          14'h225E, 14'h2AAA};
    b = '{14'h0000, 14'h0056, 14'h009C, 14'h00E0, 14'h014D, 14'h01C4, 14'h028E,
          14'h0367, 14'h04DC, 14'h067F, 14'h0941, 14'h0C4D, 14'h1185, 14'h1761,
          14'h2129, 14'h2AAA};
    return sel ? b[v] : a[v];
  endfunction

  function automatic logic [3:0] shape_level(input logic [3:0] sh, input logic [4:0] st);
    logic [3:0] up;
    logic [3:0] dn;
    up = st[3:0];
    dn = 4'd15 - st[3:0];
    if (!st[4]) return sh[2] ? up : dn;
    unique case (sh)
      4'd8, 4'd14: return dn;
      4'd10, 4'd12: return up;
      4'd11, 4'd13: return 4'd15;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic shape_holds(input logic [3:0] sh);
    return !(sh == 4'd8 || sh == 4'd10 || sh == 4'd12 || sh == 4'd14);
  endfunction
endpackage
`default_nettype wire

/* rtl/core/psg_stream_if.sv */
// ----------------------------------------------------------------------------
// psg_stream_if
// Valid/ready channel carrying a payload of parameterized width.
// ----------------------------------------------------------------------------
`default_nettype none
interface psg_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/psg_ctrl.sv */
// ----------------------------------------------------------------------------
// psg_ctrl
// Sequencer: tick loop, divider steps, filter stages, output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module psg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_mode,
  output logic                in_ready,
  output logic                res_valid,
  input  wire logic           res_ready,
  input  wire psg_pkg::stat_t stat,
  output psg_pkg::cmd_t       cmd
);
  import psg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PHASE, S_TICK, S_DIV, S_HP, S_LP, S_OUT, S_HOLD
  } state_t;

  state_t state;
  logic [TICK_W-1:0] cnt;
  logic [4:0] dcnt;

  assign in_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    cmd = '0;
    cmd.shape_load = in_valid && in_ready && in_mode;
    cmd.phase_add = in_valid && in_ready && !in_mode;
    cmd.tick = (state == S_TICK);
    cmd.div_start = (state == S_PHASE);
    cmd.div_step = (state == S_DIV);
    cmd.filt_hp = (state == S_HP);
    cmd.filt_lp = (state == S_LP);
    cmd.filt_out = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      cnt <= '0;
      dcnt <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready && !in_mode) state <= S_PHASE;
        S_PHASE: begin
          if (stat.ticks == '0) begin
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= stat.ticks;
            state <= S_TICK;
          end
        end
        S_TICK: begin
          cnt <= cnt - 1'b1;
          if (cnt == TICK_W'(1)) begin
            dcnt <= 5'd21;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == 5'd1) state <= S_HP;
        end
        S_HP: state <= S_LP;
        S_LP: state <= S_OUT;
        S_OUT: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/psg_dp.sv */
// ----------------------------------------------------------------------------
// psg_dp
// Tone, noise, envelope generators, tick accumulator, divider and filters.
// ----------------------------------------------------------------------------
`default_nettype none
module psg_dp #(
  parameter int MAX_TICKS = 63
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire psg_pkg::cfg_t  cfg,
  input  wire psg_pkg::cmd_t  cmd,
  input  wire logic [3:0]     in_shape,
  output psg_pkg::stat_t      stat,
  output logic signed [15:0]  sample
);
  import psg_pkg::*;

  logic [11:0] tcnt [3];
  logic [2:0]  tlev;
  logic [4:0]  ncnt;
  logic [16:0] nshift;
  logic [15:0] ecnt;
  logic [3:0]  esh;
  logic [4:0]  estep;
  logic [3:0]  elev;
  logic        ehold;
  logic [15:0] phase;
  logic [TICK_W-1:0] ticks;
  logic [20:0] acc;
  logic [20:0] rem;
  logic [20:0] quo;
  logic signed [15:0] hp_in;
  logic signed [17:0] hp_out, lpi0, lpi1, lpo0, lpo1;
  logic signed [15:0] out_r;

  logic [22:0] psum;
  logic [6:0]  raw;
  logic [15:0] tick_sum;
  logic [4:0]  estep_n;
  logic        ehold_n;

  assign psum = {1'b0, cfg.sample_step} + {7'd0, phase};
  assign raw = psum[22:16];
  assign stat.ticks = ticks;
  assign sample = out_r;

  // generator next state after one tick
  logic [11:0] tp [3];
  logic [11:0] tcnt_n [3];
  logic [2:0]  tlev_n;
  logic [4:0]  ncnt_n;
  logic [16:0] nshift_n;
  logic [15:0] ecnt_n;
  logic [3:0]  elev_n;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tp[c] = cfg.tone_periods[12*c +: 12];
      if (tcnt[c] <= 12'd1) begin
        tcnt_n[c] = (tp[c] == 12'd0) ? 12'd1 : tp[c];
        tlev_n[c] = ~tlev[c];
      end else begin
        tcnt_n[c] = tcnt[c] - 12'd1;
        tlev_n[c] = tlev[c];
      end
    end
    if (ncnt <= 5'd1) begin
      ncnt_n = (cfg.noise_div == 5'd0) ? 5'd1 : cfg.noise_div;
      nshift_n = {nshift[0] ^ nshift[3], nshift[16:1]};
    end else begin
      ncnt_n = ncnt - 5'd1;
      nshift_n = nshift;
    end
    estep_n = estep;
    ehold_n = ehold;
    elev_n = elev;
    if (ecnt <= 16'd1) begin
      ecnt_n = (cfg.envelope_period == 16'd0) ? 16'd1 : cfg.envelope_period;
      if (!ehold) begin
        if (estep < 5'd31) estep_n = estep + 5'd1;
        else if (shape_holds(esh)) ehold_n = 1'b1;
        else estep_n = 5'd0;
        elev_n = shape_level(esh, estep_n);
      end
    end else begin
      ecnt_n = ecnt - 16'd1;
    end
  end

  // level of one tick, taken from the state this tick produces
  always_comb begin
    tick_sum = '0;
    for (int c = 0; c < 3; c++) begin
      logic t, n;
      logic [3:0] v;
      t = cfg.mixer_bits[c] | tlev_n[c];
      n = cfg.mixer_bits[3+c] | nshift_n[0];
      v = cfg.mixer_bits[6+c] ? elev_n : cfg.channel_volumes[4*c +: 4];
      if (t && n) tick_sum = tick_sum + {2'b0, curve(cfg.chip_type, v)};
    end
  end

  // filters
  logic signed [19:0] hp_diff;
  logic signed [38:0] hp_prod;
  logic signed [22:0] hp_sh;
  logic signed [17:0] hp_sat;
  logic signed [38:0] lp_acc;
  logic signed [23:0] lp_sh;
  logic signed [17:0] lp_sat;
  logic signed [28:0] o_prod;
  logic signed [20:0] o_sh;
  logic signed [15:0] o_sat;
  always_comb begin
    hp_diff = 20'(hp_out) + 20'(signed'({1'b0, quo[14:0]})) - 20'(hp_in);
    hp_prod = 39'(hp_diff) * 39'(HP_COEF) + 39'sd32768;
    hp_sh = 23'(hp_prod >>> 16);
    if (hp_sh > 23'sd131071) hp_sat = 18'sd131071;
    else if (hp_sh < -23'sd131072) hp_sat = -18'sd131072;
    else hp_sat = hp_sh[17:0];
    lp_acc = 39'(hp_out) * 39'(LP_B0) + 39'(lpi0) * 39'(LP_B1)
           + 39'(lpi1) * 39'(LP_B0) - 39'(lpo0) * 39'(LP_A1)
           - 39'(lpo1) * 39'(LP_A2) + 39'sd16384;
    lp_sh = 24'(lp_acc >>> 15);
    if (lp_sh > 24'sd131071) lp_sat = 18'sd131071;
    else if (lp_sh < -24'sd131072) lp_sat = -18'sd131072;
    else lp_sat = lp_sh[17:0];
    o_prod = 29'(lpo0) * 29'(OUT_GAIN);
    o_sh = 21'(o_prod >>> 8);
    if (o_sh > 21'sd32767) o_sat = 16'sd32767;
    else if (o_sh < -21'sd32768) o_sat = -16'sd32768;
    else o_sat = o_sh[15:0];
  end

  logic [21:0] trial;
  assign trial = {rem, acc[20]} - {15'd0, ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) tcnt[c] <= 12'd1;
      tlev <= '0; ncnt <= 5'd1; nshift <= 17'd1;
      ecnt <= 16'd1; esh <= '0; estep <= '0; elev <= 4'd15; ehold <= 1'b0;
      phase <= '0; ticks <= '0;
      hp_in <= '0; hp_out <= '0; lpi0 <= '0; lpi1 <= '0; lpo0 <= '0; lpo1 <= '0;
      out_r <= '0; acc <= '0; rem <= '0; quo <= '0;
    end else begin
      if (cmd.shape_load) begin
        esh <= in_shape; estep <= '0; ehold <= 1'b0;
        ecnt <= (cfg.envelope_period == 16'd0) ? 16'd1 : cfg.envelope_period;
        elev <= shape_level(in_shape, 5'd0);
      end
      if (cmd.phase_add) begin
        phase <= psum[15:0];
        ticks <= ({1'b0, raw} > 8'(MAX_TICKS)) ? TICK_W'(MAX_TICKS) : TICK_W'(raw);
        acc <= '0;
      end
      if (cmd.tick) begin
        tcnt <= tcnt_n; tlev <= tlev_n; ncnt <= ncnt_n; nshift <= nshift_n;
        ecnt <= ecnt_n; estep <= estep_n; ehold <= ehold_n; elev <= elev_n;
        acc <= acc + 21'(tick_sum);
      end
      if (cmd.div_start) begin
        rem <= '0; quo <= '0;
      end
      if (cmd.div_step) begin
        // restoring division, one quotient bit per cycle
        if (!trial[21]) begin
          rem <= trial[20:0]; quo <= {quo[19:0], 1'b1};
        end else begin
          rem <= {rem[19:0], acc[20]}; quo <= {quo[19:0], 1'b0};
        end
        acc <= {acc[19:0], 1'b0};
      end
      if (cmd.filt_hp) begin
        hp_in <= signed'({1'b0, quo[14:0]});
        hp_out <= hp_sat;
      end
      if (cmd.filt_lp) begin
        lpi1 <= lpi0; lpi0 <= hp_out; lpo1 <= lpo0; lpo0 <= lp_sat;
      end
      if (cmd.filt_out) out_r <= o_sat;
      if (cmd.phase_add) out_r <= '0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/psg_three_channel_sample_renderer_unit.sv */
// ----------------------------------------------------------------------------
// psg_three_channel_sample_renderer_unit
// Three-channel square-wave generator rendering filtered audio samples.
// ----------------------------------------------------------------------------
// Channels: in_ch carries {shape, mode}; out_ch carries the 16-bit sample.
// Config writes use cfg_we/cfg_idx/cfg_data while the block is idle.
// A shape item (mode 1) is taken while idle and gives no beat.
// A render item's beat is valid once it has gone from the accepting edge
// through the phase add, T whole chip ticks (1..MAX_TICKS) of the shared
// generator update, the bit-serial restoring divider that averages the
// tick levels, then the high-pass, low-pass and gain stages.
// With no whole tick the beat (sample 0) is raised from the phase state.
// At the reset defaults T is 5 (now and then 6). A new item is taken only
// once the last one is through and its beat has been taken.
// The result waits in an output register; input is not taken while it
// waits, so a stalled receiver stalls the sender. Reset initializes all
// generator state, zeroes the filters and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "psg_three_channel_sample_renderer_unit_macros.svh"
module psg_three_channel_sample_renderer_unit #(
  parameter int MAX_TICKS = 63
) (
  input wire logic clk,
  input wire logic rst,
  psg_stream_if.sink   in_ch,
  psg_stream_if.source out_ch,
  input wire logic                    cfg_we,
  input wire logic [psg_pkg::IDX_W-1:0] cfg_idx,
  input wire logic [psg_pkg::CFG_W-1:0] cfg_data
);
  import psg_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  stat_t stat;
  logic signed [15:0] smp;
  logic [4:0] dp_cmds;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tone_periods <= 36'd16781313;
      cfg.noise_div <= 5'd1;
      cfg.mixer_bits <= 9'd63;
      cfg.channel_volumes <= '0;
      cfg.envelope_period <= 16'd1;
      cfg.chip_type <= 1'b0;
      cfg.sample_step <= 22'd329426;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TONE: cfg.tone_periods <= cfg_data;
        REG_NOISE: cfg.noise_div <= cfg_data[4:0];
        REG_MIXER: cfg.mixer_bits <= cfg_data[8:0];
        REG_VOL: cfg.channel_volumes <= cfg_data[11:0];
        REG_ENV: cfg.envelope_period <= cfg_data[15:0];
        REG_CHIP: cfg.chip_type <= cfg_data[0];
        REG_STEP: cfg.sample_step <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  psg_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_mode(in_ch.data[0]), .in_ready(in_ch.ready),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .stat, .cmd
  );

  psg_dp #(.MAX_TICKS(MAX_TICKS)) u_dp (
    .clk, .rst, .cfg, .cmd, .in_shape(in_ch.data[4:1]),
    .stat, .sample(smp)
  );

  assign out_ch.data = smp;
  assign dp_cmds = {cmd.tick, cmd.div_step, cmd.filt_hp, cmd.filt_lp, cmd.filt_out};

  `PSG_ASSERT_IMPL(a_no_take_while_out, clk, rst, out_ch.valid, !in_ch.ready)
  `PSG_ASSERT_NEXT(a_shape_no_beat, clk, rst, cmd.shape_load, !out_ch.valid)
  `PSG_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0(dp_cmds))
endmodule
`default_nettype wire
